// File: rtl/assert_macros.svh
// Assertion helper macros for the gap monitor checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, idle during reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication, idle during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// File: rtl/lgbm_pkg.sv
// ---------------------------------------------------------------------------
// lgbm_pkg
// Shared types and constants of the gap breach monitor.
// ---------------------------------------------------------------------------
package lgbm_pkg;
    localparam int NumSources = 16;
    localparam int SrcW       = 4;
    localparam logic [8:0]  QOne     = 9'd256;
    localparam logic [31:0] U32Max   = 32'hFFFF_FFFF;
    localparam logic [47:0] U48Max   = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0]  CMD_GAP  = 2'd0;
    localparam logic [1:0]  CMD_LEN  = 2'd1;
    localparam logic [1:0]  CMD_SET  = 2'd2;
    localparam logic [1:0]  REG_DTHR = 2'd0;
    localparam logic [1:0]  REG_FRAC = 2'd1;
    localparam logic [1:0]  REG_TRIG = 2'd2;
    localparam int QDepth = 2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  source;
        logic [15:0] sample_value;
    } t_req;

    typedef struct packed {
        logic        near_hit;
        logic        breach_hit;
        logic        first_near;
        logic        first_breach;
        logic        new_near_source;
        logic        new_breach_source;
        logic [31:0] near_total;
        logic [31:0] breach_total;
        logic [15:0] source_gap_max;
        logic [15:0] source_len_max;
        logic [31:0] source_exceed_count;
        logic [31:0] source_gap_count;
    } t_res;

    // Classified request passed from front to back.
    typedef struct packed {
        logic        valid_src;
        logic [1:0]  cmd;
        logic [3:0]  source;
        logic [15:0] val;
    } t_cls;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WRITE} t_state;

    function automatic logic [31:0] sat_inc32(input logic [31:0] x);
        return (x == U32Max) ? x : x + 32'd1;
    endfunction
endpackage

// File: rtl/lgbm_front.sv
// ---------------------------------------------------------------------------
// lgbm_front
// Accept requests, classify them and queue them for the back end.
// ---------------------------------------------------------------------------
module lgbm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lgbm_pkg::t_req  i_req,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_avail,
    output lgbm_pkg::t_cls  o_cls
);
    import lgbm_pkg::*;
    t_cls r_q [QDepth];
    logic r_rd, n_rd, r_wr, n_wr;
    logic [1:0] r_cnt, n_cnt;
    t_cls w_cls;

    always_comb begin
        w_cls.valid_src = ({1'b0, i_req.source} < 5'(NumSources));
        w_cls.cmd       = i_req.cmd;
        w_cls.source    = i_req.source;
        w_cls.val       = i_req.sample_value;
        n_wr  = r_wr ^ i_push;
        n_rd  = r_rd ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0; r_wr <= 1'b0; r_cnt <= 2'd0;
        end else begin
            r_rd <= n_rd; r_wr <= n_wr; r_cnt <= n_cnt;
        end
        if (i_push) r_q[r_wr] <= w_cls;
    end

    assign o_full  = (r_cnt == 2'(QDepth));
    assign o_avail = (r_cnt != 2'd0);
    assign o_cls   = r_q[r_rd];
endmodule

// File: rtl/lgbm_back.sv
// ---------------------------------------------------------------------------
// lgbm_back
// Read-modify-write of one source row per request; build the result.
// ---------------------------------------------------------------------------
module lgbm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  lgbm_pkg::t_cls  i_cls,
    input  logic [15:0]     i_dthr,
    input  logic [8:0]      i_frac,
    input  logic [15:0]     i_trig,
    output logic            o_pop,
    output logic            o_busy,
    output logic            o_done,
    output lgbm_pkg::t_res  o_res
);
    import lgbm_pkg::*;
    t_state r_st, n_st;
    logic [31:0] r_gcnt [NumSources];
    logic [47:0] r_gsum [NumSources];
    logic [15:0] r_gpk  [NumSources];
    logic [31:0] r_lcnt [NumSources];
    logic [47:0] r_lsum [NumSources];
    logic [15:0] r_lpk  [NumSources];
    logic [31:0] r_exc  [NumSources];
    logic [15:0] r_thr  [NumSources];
    logic [NumSources-1:0] r_nmem, r_bmem;
    logic r_nst, r_bst;
    logic [31:0] r_ncnt, r_bcnt;
    t_cls r_c;
    // registered row
    logic [31:0] r_gc, r_lc, r_ex;
    logic [47:0] r_gs, r_ls;
    logic [15:0] r_gp, r_lp, r_th;
    logic r_nm, r_bm;
    logic r_done;
    t_res r_res;
    // combinational results
    logic [15:0] w_thr;
    logic [8:0]  w_frac;
    logic [33:0] w_lim, w_g;
    logic w_gap, w_act, w_near, w_exc, w_brk;
    logic [31:0] w_ex;
    logic [48:0] w_s;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (i_avail) n_st = ST_READ;
            ST_READ:  n_st = ST_WRITE;
            ST_WRITE: n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_st == ST_IDLE) && i_avail;
        o_busy = (r_st != ST_IDLE);
    end

    always_comb begin
        w_gap  = r_c.valid_src && (r_c.cmd == CMD_GAP);
        w_thr  = (r_th != 16'd0) ? r_th : i_dthr;
        w_frac = (i_frac > QOne) ? QOne : i_frac;
        w_act  = w_gap && (w_thr > 16'(QOne));
        w_lim  = 34'd65536 + 34'(w_thr - 16'(QOne)) * 34'(w_frac);
        w_g    = {10'd0, r_c.val, 8'd0};
        w_near = w_act && (w_g > w_lim);
        w_exc  = w_act && (r_c.val > w_thr);
        w_ex   = w_exc ? sat_inc32(r_ex) : r_ex;
        w_brk  = w_exc && (w_ex > {16'd0, i_trig});
        w_s    = (w_gap ? {1'b0, r_gs} : {1'b0, r_ls}) + {33'd0, r_c.val};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_done <= 1'b0;
            r_nmem <= '0; r_bmem <= '0; r_nst <= 1'b0; r_bst <= 1'b0;
            r_ncnt <= '0; r_bcnt <= '0;
            for (int i = 0; i < NumSources; i++) begin
                r_gcnt[i] <= '0; r_gsum[i] <= '0; r_gpk[i] <= '0;
                r_lcnt[i] <= '0; r_lsum[i] <= '0; r_lpk[i] <= '0;
                r_exc[i] <= '0; r_thr[i] <= '0;
            end
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == ST_WRITE);
            if (r_st == ST_WRITE && r_c.valid_src) begin
                if (r_c.cmd == CMD_GAP) begin
                    r_gcnt[r_c.source] <= sat_inc32(r_gc);
                    r_gsum[r_c.source] <= w_s[48] ? U48Max : w_s[47:0];
                    if (r_c.val > r_gp) r_gpk[r_c.source] <= r_c.val;
                    r_exc[r_c.source] <= w_ex;
                    if (w_near) begin
                        r_nst <= 1'b1;
                        r_ncnt <= sat_inc32(r_ncnt);
                        r_nmem[r_c.source] <= 1'b1;
                    end
                    if (w_brk) begin
                        r_bst <= 1'b1;
                        r_bcnt <= sat_inc32(r_bcnt);
                        r_bmem[r_c.source] <= 1'b1;
                    end
                end else if (r_c.cmd == CMD_LEN) begin
                    r_lcnt[r_c.source] <= sat_inc32(r_lc);
                    r_lsum[r_c.source] <= w_s[48] ? U48Max : w_s[47:0];
                    if (r_c.val > r_lp) r_lpk[r_c.source] <= r_c.val;
                end else if (r_c.cmd == CMD_SET) begin
                    r_thr[r_c.source] <= r_c.val;
                end
            end
        end
        if (o_pop) r_c <= i_cls;
        if (r_st == ST_READ) begin
            r_gc <= r_gcnt[r_c.source]; r_gs <= r_gsum[r_c.source];
            r_gp <= r_gpk[r_c.source];  r_lc <= r_lcnt[r_c.source];
            r_ls <= r_lsum[r_c.source]; r_lp <= r_lpk[r_c.source];
            r_ex <= r_exc[r_c.source];  r_th <= r_thr[r_c.source];
            r_nm <= r_nmem[r_c.source]; r_bm <= r_bmem[r_c.source];
        end
        if (r_st == ST_WRITE) begin
            r_res.near_hit          <= w_near;
            r_res.breach_hit        <= w_brk;
            r_res.first_near        <= w_near && !r_nst;
            r_res.first_breach      <= w_brk && !r_bst;
            r_res.new_near_source   <= w_near && !r_nm;
            r_res.new_breach_source <= w_brk && !r_bm;
            r_res.near_total   <= w_near ? sat_inc32(r_ncnt) : r_ncnt;
            r_res.breach_total <= w_brk ? sat_inc32(r_bcnt) : r_bcnt;
            if (!r_c.valid_src) begin
                r_res.source_gap_max <= '0; r_res.source_len_max <= '0;
                r_res.source_exceed_count <= '0; r_res.source_gap_count <= '0;
            end else begin
                r_res.source_gap_max <= (w_gap && r_c.val > r_gp) ? r_c.val : r_gp;
                r_res.source_len_max <= (r_c.cmd == CMD_LEN && r_c.val > r_lp)
                                        ? r_c.val : r_lp;
                r_res.source_exceed_count <= w_gap ? w_ex : r_ex;
                r_res.source_gap_count    <= w_gap ? sat_inc32(r_gc) : r_gc;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// File: rtl/loop_gap_breach_monitor.sv
// ---------------------------------------------------------------------------
// loop_gap_breach_monitor
// Per-source gap watchdog: statistics, threshold checks and breach counting.
// ---------------------------------------------------------------------------
// Path: an accepted request is queued, popped into the back end, its row read
//   and the update written into the result register along with the strobe.
// Flow: the back end pops the next request only after its row read-modify-write
//   sequence (idle, read, write) ends; a two-entry queue absorbs short bursts.
// Reset: synchronous, active low; clears all statistics, flags and counters.
// The receiver cannot stall: each result shows for one cycle on o_done.
module loop_gap_breach_monitor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  lgbm_pkg::t_req  i_req,
    output logic            o_done,
    output lgbm_pkg::t_res  o_res,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data
);
    import lgbm_pkg::*;
    // configuration registers
    logic [15:0] r_dthr, r_trig;
    logic [8:0]  r_frac;
    logic w_full, w_avail, w_pop, w_bbusy;
    t_cls w_cls;

    // Hold config; write the addressed register, ignore unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dthr <= 16'd0; r_frac <= 9'd230; r_trig <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DTHR: r_dthr <= i_cfg_data;
                REG_FRAC: r_frac <= i_cfg_data[8:0];
                REG_TRIG: r_trig <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Refuse requests while the queue is full.
    assign busy = w_full;

    lgbm_front u_front (
        .i_clk, .i_rst_n,
        .i_push (start && !w_full),
        .i_req,
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_avail(w_avail),
        .o_cls  (w_cls)
    );

    lgbm_back u_back (
        .i_clk, .i_rst_n,
        .i_avail(w_avail),
        .i_cls  (w_cls),
        .i_dthr (r_dthr),
        .i_frac (r_frac),
        .i_trig (r_trig),
        .o_pop  (w_pop),
        .o_busy (w_bbusy),
        .o_done,
        .o_res
    );

    logic w_unused;
    assign w_unused = w_bbusy;
endmodule

// File: rtl/lgbm_checker.sv
// ---------------------------------------------------------------------------
// lgbm_checker
// Port-level checks of the gap breach monitor.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module lgbm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input lgbm_pkg::t_res o_res
);
    `CHK_IMPL(a_first_near, i_clk, i_rst_n, o_done && o_res.first_near, o_res.near_hit)
    `CHK_IMPL(a_brk_new, i_clk, i_rst_n, o_done && o_res.new_breach_source, o_res.breach_hit)
    `CHK_IMPL(a_nb_tot, i_clk, i_rst_n, o_done && o_res.near_hit, o_res.near_total != 32'd0)
    `CHK_NEXT(a_gap, i_clk, i_rst_n, o_done, !o_done)
    `CHK_IMPL(a_hs_known, i_clk, i_rst_n, 1'b1, !$isunknown(start) && !$isunknown(busy))
endmodule

bind loop_gap_breach_monitor lgbm_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_res
);

// File: verif/tb_loop_gap_breach_monitor.sv
// ---------------------------------------------------------------------------
// tb_loop_gap_breach_monitor
// Drives gap, length and threshold requests into the gap breach monitor,
// predicts every result from a private copy of the per-source tables and
// compares each strobed result field by field, across several register
// settings including their extremes.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_loop_gap_breach_monitor;
    import lgbm_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int         DRAIN    = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_done;
    t_res        o_res;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    loop_gap_breach_monitor dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_req     (i_req),
        .o_done    (o_done),
        .o_res     (o_res),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Predictor state: registers and per-source tables.
    logic [15:0] p_dthr;
    logic [8:0]  p_frac;
    logic [15:0] p_trig;
    logic [31:0] p_gap_cnt [NumSources];
    logic [15:0] p_gap_pk  [NumSources];
    logic [15:0] p_len_pk  [NumSources];
    logic [31:0] p_exc_cnt [NumSources];
    logic [15:0] p_src_thr [NumSources];
    logic [NumSources-1:0] p_near_set, p_breach_set;
    logic        p_near_stk, p_breach_stk;
    logic [31:0] p_near_tot, p_breach_tot;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   n_errors;
    int   idle_left;
    bit   allow_idle;
    bit   stim_done;

    function automatic logic [31:0] bump(input logic [31:0] x);
        return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    // Advance the predictor by one request and return the expected result.
    function automatic t_res predict_monitor(input t_req r);
        t_res        e;
        logic [15:0] thr;
        logic [63:0] lim;
        logic [8:0]  frac;
        int          s;
        s = r.source;
        e = '0;
        if (r.cmd == CMD_GAP) begin
            p_gap_cnt[s] = bump(p_gap_cnt[s]);
            if (r.sample_value > p_gap_pk[s]) p_gap_pk[s] = r.sample_value;
            thr = (p_src_thr[s] != 0) ? p_src_thr[s] : p_dthr;
            if (thr > 16'd256) begin
                frac = (p_frac > 9'd256) ? 9'd256 : p_frac;
                lim = 64'd65536 + 64'(thr - 16'd256) * 64'(frac);
                if (64'(r.sample_value) * 64'd256 > lim) begin
                    e.near_hit = 1'b1;
                    if (!p_near_stk) begin
                        p_near_stk   = 1'b1;
                        e.first_near = 1'b1;
                    end
                    p_near_tot = bump(p_near_tot);
                    if (!p_near_set[s]) begin
                        p_near_set[s]     = 1'b1;
                        e.new_near_source = 1'b1;
                    end
                end
                if (r.sample_value > thr) begin
                    p_exc_cnt[s] = bump(p_exc_cnt[s]);
                    if (p_exc_cnt[s] > 32'(p_trig)) begin
                        e.breach_hit = 1'b1;
                        p_breach_tot = bump(p_breach_tot);
                        if (!p_breach_stk) begin
                            p_breach_stk   = 1'b1;
                            e.first_breach = 1'b1;
                        end
                        if (!p_breach_set[s]) begin
                            p_breach_set[s]     = 1'b1;
                            e.new_breach_source = 1'b1;
                        end
                    end
                end
            end
        end else if (r.cmd == CMD_LEN) begin
            if (r.sample_value > p_len_pk[s]) p_len_pk[s] = r.sample_value;
        end else if (r.cmd == CMD_SET) begin
            p_src_thr[s] = r.sample_value;
        end
        e.near_total          = p_near_tot;
        e.breach_total        = p_breach_tot;
        e.source_gap_max      = p_gap_pk[s];
        e.source_len_max      = p_len_pk[s];
        e.source_exceed_count = p_exc_cnt[s];
        e.source_gap_count    = p_gap_cnt[s];
        return e;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Driver: offer the head of the queue, idle in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_res.push_back(predict_monitor(i_req));
                void'(pending_reqs.pop_front());
            end
            if (start && busy) begin
                // hold the request until it is taken
            end else if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start     <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 9) == 0) begin
                idle_left <= $urandom_range(0, 12);
                start     <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                start <= 1'b1;
                i_req <= pending_reqs[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_done) begin
            if (expected_res.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                e = expected_res.pop_front();
                if (o_res.near_hit !== e.near_hit) begin
                    $error("near_hit exp %0d got %0d", e.near_hit, o_res.near_hit);
                    n_errors++;
                end
                if (o_res.breach_hit !== e.breach_hit) begin
                    $error("breach_hit exp %0d got %0d", e.breach_hit, o_res.breach_hit);
                    n_errors++;
                end
                if (o_res.first_near !== e.first_near) begin
                    $error("first_near exp %0d got %0d", e.first_near, o_res.first_near);
                    n_errors++;
                end
                if (o_res.first_breach !== e.first_breach) begin
                    $error("first_breach exp %0d got %0d", e.first_breach,
                           o_res.first_breach);
                    n_errors++;
                end
                if (o_res.new_near_source !== e.new_near_source) begin
                    $error("new_near_source exp %0d got %0d", e.new_near_source,
                           o_res.new_near_source);
                    n_errors++;
                end
                if (o_res.new_breach_source !== e.new_breach_source) begin
                    $error("new_breach_source exp %0d got %0d", e.new_breach_source,
                           o_res.new_breach_source);
                    n_errors++;
                end
                if (o_res.near_total !== e.near_total) begin
                    $error("near_total exp %0d got %0d", e.near_total, o_res.near_total);
                    n_errors++;
                end
                if (o_res.breach_total !== e.breach_total) begin
                    $error("breach_total exp %0d got %0d", e.breach_total,
                           o_res.breach_total);
                    n_errors++;
                end
                if (o_res.source_gap_max !== e.source_gap_max) begin
                    $error("source_gap_max exp %0d got %0d", e.source_gap_max,
                           o_res.source_gap_max);
                    n_errors++;
                end
                if (o_res.source_len_max !== e.source_len_max) begin
                    $error("source_len_max exp %0d got %0d", e.source_len_max,
                           o_res.source_len_max);
                    n_errors++;
                end
                if (o_res.source_exceed_count !== e.source_exceed_count) begin
                    $error("source_exceed_count exp %0d got %0d",
                           e.source_exceed_count, o_res.source_exceed_count);
                    n_errors++;
                end
                if (o_res.source_gap_count !== e.source_gap_count) begin
                    $error("source_gap_count exp %0d got %0d", e.source_gap_count,
                           o_res.source_gap_count);
                    n_errors++;
                end
            end
        end
    end

    // Write one register into the block and the predictor; block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DTHR: p_dthr = data;
            REG_FRAC: p_frac = data[8:0];
            REG_TRIG: p_trig = data;
            default: ;
        endcase
    endtask

    // Wait until every queued request is taken and every result has come.
    task automatic drain_all();
        while (pending_reqs.size() != 0 || start || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic void queue_req(input logic [1:0] c, input logic [3:0] s,
                                      input logic [15:0] v);
        t_req r;
        r.cmd          = c;
        r.source       = s;
        r.sample_value = v;
        pending_reqs.push_back(r);
    endfunction

    // Mostly gaps near the live threshold so breaches actually happen.
    function automatic logic [15:0] pick_gap(input logic [3:0] s);
        logic [15:0] thr;
        int          lo, hi;
        thr = (p_src_thr[s] != 0) ? p_src_thr[s] : p_dthr;
        if (thr <= 16'd256 || $urandom_range(0, 4) == 0) return 16'($urandom);
        lo = (thr > 600) ? thr - 600 : 0;
        hi = (thr < 65535 - 600) ? thr + 600 : 65535;
        return 16'($urandom_range(lo, hi));
    endfunction

    task automatic random_phase(input int n);
        logic [1:0] c;
        logic [3:0] s;
        int         k;
        for (int i = 0; i < n; i++) begin
            s = 4'($urandom_range(0, 15));
            k = $urandom_range(0, 99);
            c = (k < 65) ? CMD_GAP : (k < 85) ? CMD_LEN : (k < 97) ? CMD_SET : CMD_NONE;
            if (c == CMD_GAP)      queue_req(c, s, pick_gap(s));
            else if (c == CMD_SET) queue_req(c, s, ($urandom_range(0, 5) == 0) ?
                                              16'd0 : 16'($urandom_range(0, 4000)));
            else                   queue_req(c, s, 16'($urandom));
        end
    endtask

    initial begin
        n_errors   = 0;
        allow_idle = 1'b1;
        stim_done  = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_DTHR;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        p_dthr = '0; p_frac = 9'd230; p_trig = 16'd1;
        for (int i = 0; i < NumSources; i++) begin
            p_gap_cnt[i] = '0; p_gap_pk[i] = '0; p_len_pk[i] = '0;
            p_exc_cnt[i] = '0; p_src_thr[i] = '0;
        end
        p_near_set = '0; p_breach_set = '0;
        p_near_stk = 1'b0; p_breach_stk = 1'b0;
        p_near_tot = '0; p_breach_tot = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: check disabled at reset, then own thresholds and extremes.
        queue_req(CMD_GAP, 4'd0, 16'hFFFF);         // no threshold anywhere
        queue_req(CMD_LEN, 4'd15, 16'hFFFF);
        queue_req(CMD_LEN, 4'd15, 16'h0000);
        queue_req(CMD_NONE, 4'd3, 16'hFFFF);        // unused command
        queue_req(CMD_SET, 4'd1, 16'd256);          // own threshold of exactly 1.0
        queue_req(CMD_GAP, 4'd1, 16'hFFFF);
        queue_req(CMD_SET, 4'd2, 16'd512);
        queue_req(CMD_GAP, 4'd2, 16'd486);          // near edge at 0.9
        queue_req(CMD_GAP, 4'd2, 16'd487);
        queue_req(CMD_GAP, 4'd2, 16'd512);          // equal, not above
        queue_req(CMD_GAP, 4'd2, 16'd513);          // first exceed forgiven
        queue_req(CMD_GAP, 4'd2, 16'd600);          // breach
        queue_req(CMD_GAP, 4'd2, 16'd700);
        queue_req(CMD_SET, 4'd2, 16'd0);            // clear own threshold
        queue_req(CMD_GAP, 4'd2, 16'd0);
        drain_all();

        // Default threshold set, fraction above one, trigger zero.
        write_reg(REG_DTHR, 16'd1024);
        write_reg(REG_FRAC, 16'h01FF);
        write_reg(REG_TRIG, 16'd0);
        queue_req(CMD_GAP, 4'd5, 16'd1024);
        queue_req(CMD_GAP, 4'd5, 16'd1025);
        queue_req(CMD_GAP, 4'd2, 16'hFFFF);
        queue_req(CMD_SET, 4'd2, 16'hFFFF);
        queue_req(CMD_GAP, 4'd2, 16'hFFFF);
        random_phase(400);
        drain_all();                                // sender holds off until empty

        write_reg(REG_FRAC, 16'd0);
        write_reg(REG_TRIG, 16'hFFFF);
        write_reg(REG_DTHR, 16'hFFFF);
        random_phase(300);
        drain_all();

        write_reg(REG_FRAC, 16'd256);
        write_reg(REG_TRIG, 16'd3);
        write_reg(REG_DTHR, 16'd300);
        random_phase(600);
        drain_all();

        write_reg(REG_FRAC, 16'($urandom_range(0, 511)));
        write_reg(REG_TRIG, 16'($urandom_range(0, 6)));
        write_reg(REG_DTHR, 16'($urandom_range(0, 3000)));
        random_phase(400);
        while (pending_reqs.size() > 200) @(posedge i_clk);
        allow_idle = 1'b0;                          // full rate for the tail
        random_phase(300);
        drain_all();
        stim_done = 1'b1;
    end

    // Final verdict.
    initial begin
        wait (stim_done);
        if (n_errors == 0 && expected_res.size() == 0)
            $display("tb_loop_gap_breach_monitor: done, clean");
        else
            $display("tb_loop_gap_breach_monitor: done, errors");
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("tb_loop_gap_breach_monitor: done, errors");
        $finish;
    end
endmodule
